// ===== rtl/tga_pixel_stream_decoder_assert.svh =====
// assertion macros for the pixel stream decoder
`ifndef TGA_PIXEL_STREAM_DECODER_ASSERT_SVH
`define TGA_PIXEL_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge out of reset
`define TPSD_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("tga decoder check failed");

// same-cycle implication
`define TPSD_ASSERT_IMPLY(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("tga decoder check failed");

// next-cycle implication
`define TPSD_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("tga decoder check failed");

`else

`define TPSD_ASSERT_ALWAYS(label, expr)
`define TPSD_ASSERT_IMPLY(label, cond, expr)
`define TPSD_ASSERT_NEXT(label, cond, expr)

`endif

`endif

// ===== rtl/tga_psd_pkg.sv =====
package tga_psd_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH      = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT     = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RUN_LENGTH_CODED = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HAS_ALPHA        = 2'd3;

	// packet header layout
	localparam int unsigned RUN_FLAG_BIT = 7;
	localparam logic [6:0] HEADER_COUNT_MASK = 7'h7f;

	// pixel constants
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [1:0] LAST_BYTE_BGR  = 2'd2;
	localparam logic [1:0] LAST_BYTE_BGRA = 2'd3;
	localparam logic [7:0] COUNT_CAP = 8'd128;

	// request to the position divider
	typedef struct packed {
		logic       start;
		logic       cancel;
		logic [7:0] dividend;
		logic [6:0] divisor;
	} div_req_t;

	// status and result of the position divider
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] quot;
		logic [6:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/tga_pixel_stream_decoder.sv =====
// Targa pixel-data decoder. Takes one byte of the pixel data area per cycle
// (raw or run-length coded truecolor, BGR or BGRA) and gives one RGBA result
// per finished pixel or run packet, with its bottom-up start row, column and
// a repeat count clipped to the end of the image. A result leaves through an
// output register, so bytes keep flowing while it waits; a byte that would
// complete a pixel is held when that register is full and not being
// taken. After a run packet longer than one pixel on an image narrower than
// 128 columns, the next position comes from the position divider; the packet
// header that follows covers it, so a byte waits only if a pixel would
// complete while the divider is still busy. Sustained rate: one byte per cycle.
`include "tga_pixel_stream_decoder_assert.svh"

module tga_pixel_stream_decoder #(
	parameter int unsigned DIM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] frame_start
	// pixel result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // red, green, blue, alpha, start_row[15:0],
	                               // start_column[15:0], repeat_count
	output logic        m_tlast,   // image_done
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tga_psd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [15:0]                            cfg_data
);

	localparam int unsigned LIN_BITS = DIM_BITS + 1;

	// configuration
	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic                rlc_q;
	logic                alpha_q;

	// decode state
	logic                exp_hdr_q;
	logic [1:0]          bip_q;
	logic                run_q;
	logic [7:0]          left_q;
	logic [7:0]          blue_q;
	logic [7:0]          green_q;
	logic [7:0]          red_q;
	logic [DIM_BITS-1:0] row_q;
	logic [DIM_BITS-1:0] col_q;
	logic                fin_q;

	// result register
	logic        out_valid_q;
	logic [7:0]  out_red_q;
	logic [7:0]  out_green_q;
	logic [7:0]  out_blue_q;
	logic [7:0]  out_alpha_q;
	logic [15:0] out_row_q;
	logic [15:0] out_col_q;
	logic [7:0]  out_count_q;
	logic        out_done_q;

	tga_psd_pkg::div_req_t div_req;
	tga_psd_pkg::div_rsp_t div_rsp;

	logic                accept;
	logic                frame_start;
	logic [7:0]          din;
	logic                dim_zero;
	logic [1:0]          last_byte;
	logic                pix_pending;

	logic                e_exp;
	logic [1:0]          e_bip;
	logic                e_run;
	logic [7:0]          e_left;
	logic                e_fin;

	logic                is_header;
	logic                is_latch;
	logic                emit;

	logic                nxt_exp;
	logic [1:0]          nxt_bip;
	logic                nxt_run;
	logic [7:0]          nxt_left;

	logic [7:0]          pkt_left;
	logic [7:0]          count;
	logic [7:0]          row_sat;
	logic [7:0]          width_sat;
	logic [15:0]         prod;
	logic [7:0]          prod_clip;
	logic [DIM_BITS-1:0] first_row_left;
	logic [7:0]          first_clip;
	logic [8:0]          remaining;
	logic                done;
	logic [7:0]          final_count;
	logic [7:0]          pix_red;
	logic [7:0]          pix_alpha;

	logic [LIN_BITS-1:0] lin;
	logic                fast_step;
	logic                wraps;
	logic [DIM_BITS-1:0] fast_col;
	logic [DIM_BITS-1:0] fast_row;

	assign accept      = s_tvalid && s_tready;
	assign frame_start = s_tuser[0];
	assign din         = s_tdata[7:0];
	assign dim_zero    = (width_q == '0) || (height_q == '0);
	assign last_byte   = alpha_q ? tga_psd_pkg::LAST_BYTE_BGRA : tga_psd_pkg::LAST_BYTE_BGR;

	// a byte in this state could complete a pixel and needs the position and the
	// result register
	assign pix_pending = !(rlc_q && exp_hdr_q) && (bip_q >= last_byte);
	assign s_tready    = !(pix_pending && (div_rsp.busy || (out_valid_q && !m_tready)));
	assign cfg_ready   = 1'b1;

	// state as seen after an optional frame start, and byte classification
	always_comb begin
		e_exp  = frame_start ? 1'b1 : exp_hdr_q;
		e_bip  = frame_start ? 2'd0 : bip_q;
		e_run  = frame_start ? 1'b0 : run_q;
		e_left = frame_start ? 8'd0 : left_q;
		e_fin  = frame_start ? dim_zero
		                     : (fin_q || dim_zero || (col_q >= width_q) || (row_q >= height_q));

		is_header = !e_fin && rlc_q && e_exp;
		is_latch  = !e_fin && !is_header && (e_bip < last_byte);
		emit      = !e_fin && !is_header && !is_latch;
	end

	// packet bookkeeping and pixel assembly
	always_comb begin
		nxt_exp  = e_exp;
		nxt_bip  = e_bip;
		nxt_run  = e_run;
		nxt_left = e_left;
		pkt_left = (e_left == 8'd0) ? 8'd1 : e_left;
		count    = 8'd1;

		if (is_header) begin
			nxt_run  = din[tga_psd_pkg::RUN_FLAG_BIT];
			nxt_left = {1'b0, din[6:0] & tga_psd_pkg::HEADER_COUNT_MASK} + 8'd1;
			nxt_exp  = 1'b0;
			nxt_bip  = 2'd0;
		end else if (is_latch) begin
			nxt_bip = e_bip + 2'd1;
		end else if (emit) begin
			nxt_bip = 2'd0;
			if (rlc_q) begin
				if (e_run) begin
					count    = pkt_left;
					nxt_left = 8'd0;
					nxt_exp  = 1'b1;
				end else begin
					nxt_left = pkt_left - 8'd1;
					nxt_exp  = (pkt_left == 8'd1);
				end
			end
		end

		pix_red   = (e_bip == 2'd2) ? din : red_q;
		pix_alpha = alpha_q ? din : tga_psd_pkg::ALPHA_OPAQUE;
	end

	// pixels left in the image, saturated above the largest count
	always_comb begin
		row_sat   = (row_q >= DIM_BITS'(tga_psd_pkg::COUNT_CAP)) ? tga_psd_pkg::COUNT_CAP
		                                                         : row_q[7:0];
		width_sat = (width_q >= DIM_BITS'(tga_psd_pkg::COUNT_CAP)) ? tga_psd_pkg::COUNT_CAP
		                                                           : width_q[7:0];
		prod      = row_sat * width_sat;
		prod_clip = (prod[15:8] != 8'd0) ? 8'hff : prod[7:0];
		first_row_left = width_q - col_q;
		first_clip = (first_row_left > DIM_BITS'(255)) ? 8'hff : first_row_left[7:0];
		remaining  = {1'b0, prod_clip} + {1'b0, first_clip};
		done        = ({1'b0, count} >= remaining);
		final_count = done ? remaining[7:0] : count;
	end

	// next position; at most one row step unless the image is narrow
	always_comb begin
		lin       = {1'b0, col_q} + LIN_BITS'(count);
		fast_step = (count == 8'd1) || (width_q >= DIM_BITS'(tga_psd_pkg::COUNT_CAP));
		wraps     = (lin >= {1'b0, width_q});
		fast_col  = wraps ? DIM_BITS'(lin - {1'b0, width_q}) : lin[DIM_BITS-1:0];
		fast_row  = wraps ? (row_q - DIM_BITS'(1)) : row_q;

		div_req.start    = accept && emit && !done && !fast_step;
		div_req.cancel   = accept && frame_start;
		div_req.dividend = lin[7:0];
		div_req.divisor  = width_q[6:0];
	end

	tga_psd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(1);
			height_q <= DIM_BITS'(1);
			rlc_q    <= 1'b0;
			alpha_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tga_psd_pkg::CFG_IMAGE_WIDTH:      width_q  <= cfg_data[DIM_BITS-1:0];
				tga_psd_pkg::CFG_IMAGE_HEIGHT:     height_q <= cfg_data[DIM_BITS-1:0];
				tga_psd_pkg::CFG_RUN_LENGTH_CODED: rlc_q    <= cfg_data[0];
				tga_psd_pkg::CFG_HAS_ALPHA:        alpha_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// decode state and byte latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_hdr_q <= 1'b1;
			bip_q     <= 2'd0;
			run_q     <= 1'b0;
			left_q    <= 8'd0;
			blue_q    <= 8'd0;
			green_q   <= 8'd0;
			red_q     <= 8'd0;
			fin_q     <= 1'b0;
		end else if (accept) begin
			exp_hdr_q <= nxt_exp;
			bip_q     <= nxt_bip;
			run_q     <= nxt_run;
			left_q    <= nxt_left;
			fin_q     <= e_fin || (emit && done);
			if (is_latch) begin
				case (e_bip)
					2'd0:    blue_q  <= din;
					2'd1:    green_q <= din;
					default: red_q   <= din;
				endcase
			end
			if (emit && (e_bip == 2'd2)) begin
				red_q <= din;
			end
		end
	end

	// image position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept && frame_start) begin
			row_q <= height_q - DIM_BITS'(1);
			col_q <= '0;
		end else if (accept && emit && !done && fast_step) begin
			row_q <= fast_row;
			col_q <= fast_col;
		end else if (div_rsp.done) begin
			row_q <= row_q - DIM_BITS'(div_rsp.quot);
			col_q <= DIM_BITS'(div_rsp.rem);
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_red_q   <= pix_red;
			out_green_q <= green_q;
			out_blue_q  <= blue_q;
			out_alpha_q <= pix_alpha;
			out_row_q   <= 16'(row_q);
			out_col_q   <= 16'(col_q);
			out_count_q <= final_count;
			out_done_q  <= done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_col_q, out_row_q,
	                   out_alpha_q, out_blue_q, out_green_q, out_red_q};
	assign m_tlast  = out_done_q;

	// a pixel never completes while the position is still being divided
	`TPSD_ASSERT_IMPLY(a_no_emit_in_div, accept && emit, !div_rsp.busy)
	// a new result never overwrites one that has not been transferred
	`TPSD_ASSERT_IMPLY(a_no_overwrite, accept && emit, !out_valid_q || m_tready)
	// the divider leaves the column inside the row
	`TPSD_ASSERT_NEXT(a_div_col_in_row, div_rsp.done && !div_req.cancel, col_q < width_q)
	// a result always covers at least one pixel
	`TPSD_ASSERT_IMPLY(a_count_nonzero, out_valid_q, out_count_q != 8'd0)

endmodule

// ===== rtl/tga_psd_div.sv =====
// small restoring divider for the position update after a run packet,
// four quotient bits per cycle, result shown on rsp while done is high
module tga_psd_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tga_psd_pkg::div_req_t req,
	output tga_psd_pkg::div_rsp_t rsp
);

	logic       busy_q;
	logic       pass_q;
	logic [7:0] num_q;
	logic [6:0] rem_q;
	logic [7:0] quot_q;
	logic [6:0] div_q;

	logic [7:0] num_nxt;
	logic [6:0] rem_nxt;
	logic [7:0] quot_nxt;

	// four dependent compare-subtract steps
	always_comb begin
		logic [7:0] trial;
		num_nxt  = num_q;
		rem_nxt  = rem_q;
		quot_nxt = quot_q;
		for (int i = 0; i < 4; i++) begin
			trial = {rem_nxt, num_nxt[7]};
			if (trial >= {1'b0, div_q}) begin
				trial    = trial - {1'b0, div_q};
				quot_nxt = {quot_nxt[6:0], 1'b1};
			end else begin
				quot_nxt = {quot_nxt[6:0], 1'b0};
			end
			rem_nxt = trial[6:0];
			num_nxt = {num_nxt[6:0], 1'b0};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pass_q <= 1'b0;
		end else if (req.cancel) begin
			busy_q <= 1'b0;
			pass_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			pass_q <= 1'b0;
		end else if (busy_q) begin
			pass_q <= ~pass_q;
			if (pass_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			rem_q  <= '0;
			quot_q <= '0;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			num_q  <= num_nxt;
			rem_q  <= rem_nxt;
			quot_q <= quot_nxt;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && pass_q;
	assign rsp.quot = quot_nxt;
	assign rsp.rem  = rem_nxt;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// drain pause covers the output register and the position divider;
	// watchdog limit is well above the long receiver hold-off plus the longest
	// random stall at 65 percent idling
	localparam int DRAIN_PAUSE    = 24;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		logic [7:0] data;
		logic       fs;
	} stream_byte_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] row;
		logic [15:0] column;
		logic [7:0]  count;
		logic        done;
	} pixel_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
	logic [0:0]  s_tuser = 1'b0;    // [0] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // red, green, blue, alpha, start_row, start_column,
	                                // repeat_count
	logic        m_tlast;           // image_done
	logic                                   cfg_valid = 1'b0;
	logic                                   cfg_ready;
	logic [tga_psd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [15:0]                            cfg_data = 16'd0;

	tga_pixel_stream_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bytes waiting to be driven and pixels the decoder owes us
	stream_byte_t  pending_bytes[$];
	pixel_result_t expected_pixels[$];

	int          fail_count = 0;
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int unsigned bytes_queued = 0;
	logic        start_next = 1'b0;
	pixel_result_t pred_res;
	stream_byte_t  next_byte;

	// decoder shadow: geometry and format
	logic [15:0] geom_width, geom_height;
	logic        geom_rle, geom_alpha;

	// decoder shadow: packet, pixel and position state
	logic        hdr_expected, pkt_is_run, img_finished;
	logic [1:0]  byte_idx;
	logic [7:0]  pkt_left;
	logic [7:0]  blue_l, green_l, red_l;
	logic [15:0] row_pos, col_pos;

	initial forever #2 clk = ~clk;

	// ---------------------------------------------------------------------
	// pixel prediction
	// ---------------------------------------------------------------------

	function automatic void restart_frame();
		hdr_expected = 1'b1;
		byte_idx     = 2'd0;
		pkt_is_run   = 1'b0;
		pkt_left     = 8'd0;
		row_pos      = geom_height - 16'd1;
		col_pos      = 16'd0;
		img_finished = (geom_width == 0 || geom_height == 0);
	endfunction

	function automatic void shadow_reset();
		geom_width  = 16'd1;
		geom_height = 16'd1;
		geom_rle    = 1'b0;
		geom_alpha  = 1'b0;
		blue_l      = 8'd0;
		green_l     = 8'd0;
		red_l       = 8'd0;
		restart_frame();
	endfunction

	function automatic void apply_register(input logic [tga_psd_pkg::CFG_INDEX_BITS-1:0] idx,
	                                       input logic [15:0] val);
		case (idx)
			tga_psd_pkg::CFG_IMAGE_WIDTH:      geom_width  = val;
			tga_psd_pkg::CFG_IMAGE_HEIGHT:     geom_height = val;
			tga_psd_pkg::CFG_RUN_LENGTH_CODED: geom_rle    = val[0];
			tga_psd_pkg::CFG_HAS_ALPHA:        geom_alpha  = val[0];
			default: ;
		endcase
	endfunction

	// one byte into the shadow decoder; returns 1 when a pixel result is due
	function automatic bit decode_byte(input logic [7:0] b, input logic fs,
	                                   output pixel_result_t res);
		logic [1:0]  last_idx;
		logic [7:0]  red_v;
		logic [31:0] cnt, left, remaining, lin, w32, quot, modv;
		res = '0;
		if (fs)
			restart_frame();
		if (!img_finished && (geom_width == 0 || geom_height == 0 ||
		                      col_pos >= geom_width || row_pos >= geom_height))
			img_finished = 1'b1;
		if (img_finished)
			return 1'b0;

		// packet header
		if (geom_rle && hdr_expected) begin
			pkt_is_run   = b[tga_psd_pkg::RUN_FLAG_BIT];
			pkt_left     = {1'b0, b[6:0] & tga_psd_pkg::HEADER_COUNT_MASK} + 8'd1;
			hdr_expected = 1'b0;
			byte_idx     = 2'd0;
			return 1'b0;
		end

		// gather color bytes
		last_idx = geom_alpha ? tga_psd_pkg::LAST_BYTE_BGRA : tga_psd_pkg::LAST_BYTE_BGR;
		if (byte_idx < last_idx) begin
			case (byte_idx)
				2'd0:    blue_l  = b;
				2'd1:    green_l = b;
				default: red_l   = b;
			endcase
			byte_idx = byte_idx + 2'd1;
			return 1'b0;
		end

		// pixel complete
		red_v = (byte_idx == 2'd2) ? b : red_l;
		if (byte_idx == 2'd2)
			red_l = b;
		res.alpha = geom_alpha ? b : tga_psd_pkg::ALPHA_OPAQUE;
		byte_idx = 2'd0;

		cnt = 1;
		if (geom_rle) begin
			left = (pkt_left != 0) ? {24'd0, pkt_left} : 32'd1;
			if (pkt_is_run) begin
				cnt          = left;
				pkt_left     = 8'd0;
				hdr_expected = 1'b1;
			end else begin
				lin      = left - 1;
				pkt_left = lin[7:0];
				if (pkt_left == 0)
					hdr_expected = 1'b1;
			end
		end

		// clip to the pixels left in the image
		w32 = {16'd0, geom_width};
		remaining = {16'd0, row_pos} * w32 + (w32 - {16'd0, col_pos});
		res.done = 1'b0;
		if (cnt >= remaining) begin
			cnt = remaining;
			res.done = 1'b1;
		end

		res.red    = red_v;
		res.green  = green_l;
		res.blue   = blue_l;
		res.row    = row_pos;
		res.column = col_pos;
		res.count  = cnt[7:0];

		// advance in raster order, rows counting down
		if (res.done) begin
			img_finished = 1'b1;
		end else begin
			lin     = {16'd0, col_pos} + cnt;
			quot    = lin / w32;
			modv    = lin % w32;
			row_pos = row_pos - quot[15:0];
			col_pos = modv[15:0];
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------------

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 50)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
	                             input logic [15:0] want);
		if (got !== want)
			log_failure($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_pixel(input logic [71:0] d, input logic last);
		pixel_result_t want;
		if (expected_pixels.size() == 0) begin
			log_failure($sformatf("pixel transfer with nothing pending: %h", d));
			return;
		end
		want = expected_pixels.pop_front();
		compare_field("red", 16'(d[7:0]), 16'(want.red));
		compare_field("green", 16'(d[15:8]), 16'(want.green));
		compare_field("blue", 16'(d[23:16]), 16'(want.blue));
		compare_field("alpha", 16'(d[31:24]), 16'(want.alpha));
		compare_field("start_row", d[47:32], want.row);
		compare_field("start_column", d[63:48], want.column);
		compare_field("repeat_count", 16'(d[71:64]), 16'(want.count));
		compare_field("image_done", 16'(last), 16'(want.done));
	endtask

	// ---------------------------------------------------------------------
	// byte driver: predicts on each accepted transfer, then offers the next byte
	// ---------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (decode_byte(s_tdata, s_tuser[0], pred_res))
					expected_pixels.push_back(pred_res);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_byte = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_byte.data;
					s_tuser  <= next_byte.fs;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// pixel monitor and ready generation, with the long hold-off on request
	// ---------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_pixel(m_tdata, m_tlast);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	task automatic cfg_write(input logic [tga_psd_pkg::CFG_INDEX_BITS-1:0] idx,
	                         input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || expected_pixels.size() != 0);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		stream_byte_t item;
		item.data = b;
		item.fs   = start_next;
		start_next = 1'b0;
		pending_bytes.push_back(item);
		bytes_queued++;
	endtask

	task automatic push_pixel(input logic [7:0] b, input logic [7:0] g,
	                          input logic [7:0] r, input logic [7:0] a);
		push_byte(b);
		push_byte(g);
		push_byte(r);
		if (geom_alpha)
			push_byte(a);
	endtask

	function automatic logic [7:0] pick_color();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic push_pixel_rand();
		push_pixel(pick_color(), pick_color(), pick_color(), pick_color());
	endtask

	function automatic logic [15:0] pick_dim();
		case ($urandom_range(19))
			0:       return 16'hFFFF;
			1:       return 16'($urandom_range(127, 129));
			2:       return 16'($urandom_range(7, 12));
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	// well-formed image with random content, sometimes cut short
	task automatic queue_frame();
		int unsigned total_px, done_px, budget, base, k, i;
		logic        run_flag;
		logic [6:0]  k_field;
		total_px = {16'd0, geom_width} * {16'd0, geom_height};
		budget = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : 120;
		base = bytes_queued;
		done_px = 0;
		start_next = 1'b1;
		while (done_px < total_px && bytes_queued - base < budget) begin
			if (geom_rle) begin
				case ($urandom_range(7))
					0:       k = 128;
					1:       k = $urandom_range(1, 128);
					default: k = $urandom_range(1, 4);
				endcase
				run_flag = 1'($urandom_range(1));
				k_field = 7'(k - 1);
				push_byte({run_flag, k_field});
				if (run_flag) begin
					push_pixel_rand();
				end else begin
					for (i = 0; i < k && bytes_queued - base < budget; i++)
						push_pixel_rand();
				end
				done_px += k;
			end else begin
				push_pixel_rand();
				done_px++;
			end
		end
		// bytes past the end of the image
		repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(255)));
	endtask

	// random bytes with stray frame starts
	task automatic queue_noise();
		start_next = 1'b1;
		repeat ($urandom_range(8, 20)) begin
			if ($urandom_range(7) == 0)
				start_next = 1'b1;
			push_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int src_pct, input int sink_pct, input int unsigned goal);
		int unsigned goal_at;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		goal_at = bytes_queued + goal;
		while (bytes_queued < goal_at) begin
			cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, pick_dim());
			cfg_write(tga_psd_pkg::CFG_IMAGE_HEIGHT, pick_dim());
			cfg_write(tga_psd_pkg::CFG_RUN_LENGTH_CODED, 16'($urandom_range(1)));
			cfg_write(tga_psd_pkg::CFG_HAS_ALPHA, 16'($urandom_range(1)));
			if ($urandom_range(9) == 0)
				queue_noise();
			else
				queue_frame();
			if ($urandom_range(2) == 0)
				queue_frame();
			wait_drained();
		end
	endtask

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------

	initial begin
		shadow_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		src_idle_pct  = 6;
		sink_idle_pct = 65;
		@(negedge clk);

		// reset geometry: one BGR pixel, then a byte past the end
		start_next = 1'b1;
		push_pixel(8'h00, 8'hFF, 8'hA5, 8'h00);
		push_byte(8'h7E);
		wait_drained();

		// coded 3x2 BGR: run of two, raw packet of two, run clipped at the end
		cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, 16'd3);
		cfg_write(tga_psd_pkg::CFG_IMAGE_HEIGHT, 16'd2);
		cfg_write(tga_psd_pkg::CFG_RUN_LENGTH_CODED, 16'd1);
		start_next = 1'b1;
		push_byte(8'h81);
		push_pixel(8'h11, 8'h22, 8'h33, 8'h00);
		push_byte(8'h01);
		push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
		push_pixel(8'h00, 8'hFF, 8'h00, 8'h00);
		push_byte(8'hFF);
		push_pixel(8'h5A, 8'hA5, 8'h3C, 8'h00);
		push_byte(8'hC3);
		wait_drained();

		// alpha switched off in the middle of a pixel
		cfg_write(tga_psd_pkg::CFG_RUN_LENGTH_CODED, 16'd0);
		cfg_write(tga_psd_pkg::CFG_HAS_ALPHA, 16'd1);
		cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, 16'd2);
		cfg_write(tga_psd_pkg::CFG_IMAGE_HEIGHT, 16'd1);
		start_next = 1'b1;
		push_byte(8'h10);
		push_byte(8'h20);
		push_byte(8'h30);
		wait_drained();
		cfg_write(tga_psd_pkg::CFG_HAS_ALPHA, 16'd0);
		push_byte(8'h40);
		wait_drained();

		// narrower image leaves the position outside it
		cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, 16'd1);
		push_byte(8'h55);
		wait_drained();

		// mode switched in the middle of a raw packet
		cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, 16'd4);
		cfg_write(tga_psd_pkg::CFG_RUN_LENGTH_CODED, 16'd1);
		start_next = 1'b1;
		push_byte(8'h02);
		push_pixel(8'h01, 8'h02, 8'h03, 8'h00);
		wait_drained();
		cfg_write(tga_psd_pkg::CFG_RUN_LENGTH_CODED, 16'd0);
		push_pixel(8'h04, 8'h05, 8'h06, 8'h00);
		wait_drained();
		cfg_write(tga_psd_pkg::CFG_RUN_LENGTH_CODED, 16'd1);
		push_pixel(8'h07, 8'h08, 8'h09, 8'h00);
		wait_drained();

		// zero width: every byte is dropped
		cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, 16'd0);
		start_next = 1'b1;
		push_byte(8'h80);
		push_byte(8'hFF);
		push_byte(8'h00);
		wait_drained();

		// largest image, coded BGRA
		cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
		cfg_write(tga_psd_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
		cfg_write(tga_psd_pkg::CFG_HAS_ALPHA, 16'd1);
		start_next = 1'b1;
		push_byte(8'hFF);
		push_pixel(8'h12, 8'h34, 8'h56, 8'h78);
		push_byte(8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		wait_drained();

		// random images under two idling patterns
		run_random(6, 65, 100);
		run_random(65, 6, 100);

		// receiver holds off while a raw image keeps streaming in
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		cfg_write(tga_psd_pkg::CFG_IMAGE_WIDTH, 16'd8);
		cfg_write(tga_psd_pkg::CFG_IMAGE_HEIGHT, 16'd8);
		cfg_write(tga_psd_pkg::CFG_RUN_LENGTH_CODED, 16'd0);
		cfg_write(tga_psd_pkg::CFG_HAS_ALPHA, 16'd0);
		hold_reqs = hold_reqs + 1;
		start_next = 1'b1;
		repeat (64) push_pixel_rand();
		wait_drained();

		run_random(0, 0, 100);

		if (fail_count == 0 && expected_pixels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
